>>> rtl/core/rspe_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder package
// Shared constants, types and GF(256) arithmetic for the parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

    localparam int MAX_PARITY_DEF = 32;
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] PARITY_RESET = 6'd10;
    localparam logic [8:0] FIELD_POLY = 9'h11d;

    typedef enum logic {
        ST_BUILD,
        ST_RUN
    } rspe_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rspe_q_stat_t;

    // Multiply two field elements, reducing by the field polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x[7:0];
            end
            x = x << 1;
            if (x[8])
            begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rspe_front.sv
// ----------------------------------------------------------------------------
// Parity encoder front end
// Builds the generator after reset or a count write, then runs the remainder
// register on each accepted byte and hands a snapshot to the queue on last.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_front #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
    parameter int CW = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rspe_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          last_byte,
    input  wire rspe_pkg::rspe_q_stat_t        q_stat,
    output logic                               q_push,
    output logic [MAX_PARITY-1:0][7:0]         q_data,
    output logic [CW-1:0]                      n_out
);
    import rspe_pkg::*;

    localparam int IDXW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam logic [8:0] MAX9 = 9'(MAX_PARITY);

    rspe_state_t state_reg, state_next;
    logic [MAX_PARITY:0][7:0]   g_reg, g_next;
    logic [MAX_PARITY-1:0][7:0] rem_reg, rem_next;
    logic [7:0]                 root_reg, root_next;
    logic [CW-1:0]              step_reg, step_next;
    logic [CW-1:0]              n_reg, n_next;

    logic [MAX_PARITY-1:0][7:0] lfsr;
    logic [CW-1:0]              n_m1;
    logic [7:0]                 fb;
    logic                       accept;

    // Clamp a written count into the range 1 to MAX_PARITY.
    function automatic logic [CW-1:0] eff_count(input logic [CFG_W-1:0] v);
        logic [8:0] v9;
        v9 = {3'b000, v};
        if (v9 == 9'd0)
        begin
            v9 = 9'd1;
        end
        else if (v9 > MAX9)
        begin
            v9 = MAX9;
        end
        return v9[CW-1:0];
    endfunction

    function automatic logic [MAX_PARITY:0][7:0] g_init();
        logic [MAX_PARITY:0][7:0] g;
        g = '0;
        g[0] = 8'd1;
        return g;
    endfunction

    assign in_stall = (state_reg != ST_RUN) || q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign n_m1     = n_reg - CW'(1);
    assign fb       = data_byte ^ rem_reg[n_m1[IDXW-1:0]];
    assign n_out    = n_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_PARITY; k++)
        begin
            if (k == 0)
            begin
                lfsr[k] = gf_mul(fb, g_reg[0]);
            end
            else if (CW'(k) < n_reg)
            begin
                lfsr[k] = rem_reg[k-1] ^ gf_mul(fb, g_reg[k]);
            end
            else
            begin
                lfsr[k] = rem_reg[k];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        q_push     = 1'b0;
        q_data     = lfsr;

        unique case (state_reg)
            ST_BUILD:
            begin
                // Multiply the generator by (x + root) in one step.
                g_next[0] = gf_mul(root_reg, g_reg[0]);
                for (int k = 1; k <= MAX_PARITY; k++)
                begin
                    g_next[k] = g_reg[k-1] ^ gf_mul(root_reg, g_reg[k]);
                end
                root_next = gf_mul(root_reg, 8'd2);
                step_next = step_reg + CW'(1);
                if (step_reg == n_m1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (last_byte)
                    begin
                        q_push   = 1'b1;
                        rem_next = '0;
                    end
                    else
                    begin
                        rem_next = lfsr;
                    end
                end
            end
            default:
            begin
                state_next = ST_BUILD;
            end
        endcase

        // A count write restarts the build and drops any partial message.
        if (cfg_we)
        begin
            state_next = ST_BUILD;
            n_next     = eff_count(cfg_wdata);
            g_next     = g_init();
            root_next  = 8'd1;
            step_next  = '0;
            rem_next   = '0;
            q_push     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            n_reg     <= eff_count(PARITY_RESET);
            g_reg     <= g_init();
            root_reg  <= 8'd1;
            step_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            g_reg     <= g_next;
            root_reg  <= root_next;
            step_reg  <= step_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rspe_queue.sv
// ----------------------------------------------------------------------------
// Parity snapshot queue
// Two-entry queue of finished remainders between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_queue #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [MAX_PARITY-1:0][7:0]    wdata,
    input  wire logic                          pop,
    output logic [MAX_PARITY-1:0][7:0]         rdata,
    output rspe_pkg::rspe_q_stat_t             stat
);
    import rspe_pkg::*;

    logic [MAX_PARITY-1:0][7:0] data_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rspe_back.sv
// ----------------------------------------------------------------------------
// Parity encoder back end
// Serializes one queued remainder as parity bytes, highest power first,
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_back #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
    parameter int CW = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rspe_pkg::rspe_q_stat_t        q_stat,
    input  wire logic [MAX_PARITY-1:0][7:0]    q_rdata,
    output logic                               q_pop,
    input  wire logic [CW-1:0]                 n_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         parity_byte,
    output logic                               last_parity
);
    import rspe_pkg::*;

    localparam int IDXW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    logic [MAX_PARITY-1:0][7:0] buf_reg, buf_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       ov_reg, ov_next;
    logic [7:0]                 pb_reg, pb_next;
    logic                       lp_reg, lp_next;
    logic [CW-1:0]              cnt_m1;
    logic                       emit;

    assign cnt_m1 = cnt_reg - CW'(1);
    assign emit   = (cnt_reg != '0) && (!ov_reg || !out_stall);
    // The next run loads as the current one hands over its final byte.
    assign q_pop  = !q_stat.empty && ((cnt_reg == '0) || (emit && (cnt_reg == CW'(1))));

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        pb_next  = pb_reg;
        lp_next  = lp_reg;
        ov_next  = ov_reg && out_stall;
        if (emit)
        begin
            pb_next  = buf_reg[cnt_m1[IDXW-1:0]];
            lp_next  = (cnt_reg == CW'(1));
            ov_next  = 1'b1;
            cnt_next = cnt_m1;
        end
        if (q_pop)
        begin
            buf_next = q_rdata;
            cnt_next = n_in;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        pb_reg  <= pb_next;
        lp_reg  <= lp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    assign out_valid   = ov_reg;
    assign parity_byte = pb_reg;
    assign last_parity = lp_reg;

endmodule

`default_nettype wire

>>> rtl/core/reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder, GF(256), field polynomial 0x11d
// Systematic encoder: message bytes in, parity bytes out after each last byte.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we                 cfg_wdata (parity count)
//   in        in         in_valid / in_stall    data_byte, last_byte
//   out       out        out_valid / out_stall  parity_byte, last_parity
//
// One message byte per unstalled cycle updates all remainder bytes at once.
// A message yields n registered parity bytes, one per unstalled cycle.
// After reset or a count write the generator is built while input is stalled.
// A two-entry queue of remainders decouples input from output; after the build, input stalls
// only while both entries are held and the output side is stalled or busy.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rspe_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          last_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         parity_byte,
    output logic                               last_parity
);
    import rspe_pkg::*;

    localparam int CW = $clog2(MAX_PARITY + 1);

    rspe_q_stat_t               q_stat;
    logic                       q_push;
    logic                       q_pop;
    logic [MAX_PARITY-1:0][7:0] q_wdata;
    logic [MAX_PARITY-1:0][7:0] q_rdata;
    logic [CW-1:0]              n_cur;

    rspe_front #(
        .MAX_PARITY (MAX_PARITY),
        .CW         (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .n_out     (n_cur)
    );

    rspe_queue #(
        .MAX_PARITY (MAX_PARITY)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    rspe_back #(
        .MAX_PARITY (MAX_PARITY),
        .CW         (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .n_in        (n_cur),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .parity_byte (parity_byte),
        .last_parity (last_parity)
    );

endmodule

`default_nettype wire

>>> bench/reed_solomon_parity_encoder_tb.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder testbench
// Streams messages into the encoder and predicts every parity byte with an
// independent GF(256) model. The model rebuilds the generator on each count
// write. The source works in random bursts and the sink stalls in its own
// patterns. Each parity transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 10;
    localparam int MAXP = rspe_pkg::MAX_PARITY_DEF;
    localparam int SETTLE_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [7:0] REDUCE_LOW = 8'h1d;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } stall_mode_t;

    typedef struct {
        logic [7:0] value;
        logic       closing;
    } parity_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rspe_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'h00;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] parity_byte;
    logic last_parity;

    // Predictor state.
    logic [7:0] remainder_model [0:MAXP-1];
    logic [7:0] generator_model [0:MAXP-1];
    int active_count;
    parity_exp_t parity_due [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;
    int max_gap = 1;
    stall_mode_t stall_mode = STALL_NONE;
    int stall_hold = 0;
    bit stall_level = 1'b0;

    reed_solomon_parity_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .parity_byte (parity_byte),
        .last_parity (last_parity)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] shifted;
        acc = 8'h00;
        shifted = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ shifted;
            end
            shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? REDUCE_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Builds the product of (x + alpha^i) and clears the remainder.
    task automatic load_generator(input logic [rspe_pkg::CFG_W-1:0] value);
        logic [7:0] poly [0:MAXP];
        logic [7:0] root;
        int n;
        n = (value == 0) ? 1 : ((value > MAXP) ? MAXP : int'(value));
        foreach (poly[k])
        begin
            poly[k] = 8'h00;
        end
        poly[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < n; i++)
        begin
            for (int k = i + 1; k > 0; k--)
            begin
                poly[k] = poly[k - 1] ^ gf_times(root, poly[k]);
            end
            poly[0] = gf_times(root, poly[0]);
            root = gf_times(root, 8'h02);
        end
        for (int k = 0; k < MAXP; k++)
        begin
            generator_model[k] = (k < n) ? poly[k] : 8'h00;
            remainder_model[k] = 8'h00;
        end
        active_count = n;
    endtask

    // Shifts one message byte through the remainder; a last byte releases the parity.
    task automatic encoder_absorb(input logic [7:0] value, input logic tail);
        logic [7:0] feedback;
        parity_exp_t item;
        feedback = value ^ remainder_model[active_count - 1];
        for (int k = active_count - 1; k > 0; k--)
        begin
            remainder_model[k] = remainder_model[k - 1] ^ gf_times(feedback, generator_model[k]);
        end
        remainder_model[0] = gf_times(feedback, generator_model[0]);
        if (tail)
        begin
            for (int k = 0; k < active_count; k++)
            begin
                item.value = remainder_model[active_count - 1 - k];
                item.closing = (k == active_count - 1);
                parity_due.push_back(item);
            end
            foreach (remainder_model[k])
            begin
                remainder_model[k] = 8'h00;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on %s: got %02h, expected %02h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic tail);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
            begin
                gap = $urandom_range(1, max_gap);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= value;
        last_byte <= tail;
        do @(posedge clk); while (in_stall);
        encoder_absorb(value, tail);
    endtask

    // Lets every predicted parity byte drain, then gives the pipeline time to go quiet.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (parity_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_parity_count(input logic [rspe_pkg::CFG_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        load_generator(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_idling;
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        gaps_on = $urandom_range(0, 2) != 0;
        max_gap = $urandom_range(1, 10);
        burst_left = 0;
    endtask

    task automatic send_message(input int length);
        for (int k = 0; k < length; k++)
        begin
            send_byte(8'($urandom_range(0, 255)), k == length - 1);
        end
    endtask

    task automatic test_reset_count;
        pick_idling();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b1);
    endtask

    task automatic test_count_limits;
        // A zero count behaves as one parity byte.
        set_parity_count('0);
        pick_idling();
        send_byte(8'hff, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        // Counts above the maximum saturate.
        set_parity_count('1);
        send_byte(8'h01, 1'b1);
        set_parity_count(6'(MAXP));
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        set_parity_count(6'd1);
        send_byte(8'h5a, 1'b1);
    endtask

    task automatic test_mid_message_write;
        set_parity_count(6'd7);
        pick_idling();
        send_byte(8'h12, 1'b0);
        send_byte(8'hed, 1'b0);
        send_byte(8'h33, 1'b0);
        // The rewrite discards the partial message.
        set_parity_count(6'd12);
        send_byte(8'hc4, 1'b0);
        send_byte(8'h3b, 1'b1);
    endtask

    task automatic test_random_traffic;
        int sent;
        int length;
        logic [rspe_pkg::CFG_W-1:0] count;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: count = 6'd1;
                1: count = 6'(MAXP);
                2: count = '1;
                default: count = 6'($urandom_range(0, 63));
            endcase
            set_parity_count(count);
            pick_idling();
            sent = 0;
            while (sent < 30)
            begin
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(1, 6);
                send_message(length);
                sent += length;
            end
            // Now and then leave a message open so the next write cuts it off.
            if ($urandom_range(0, 3) == 0)
            begin
                length = $urandom_range(1, 3);
                for (int k = 0; k < length; k++)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            case (stall_mode)
                STALL_NONE:
                begin
                    stall_level = 1'b0;
                    stall_hold = 1;
                end
                STALL_LIGHT:
                begin
                    stall_level = $urandom_range(0, 99) < 20;
                    stall_hold = 1;
                end
                STALL_HEAVY:
                begin
                    stall_level = $urandom_range(0, 99) < 60;
                    stall_hold = $urandom_range(1, 4);
                end
                default:
                begin
                    stall_level = ~stall_level;
                    stall_hold = stall_level ? $urandom_range(1, 12) : $urandom_range(1, 8);
                end
            endcase
        end
        stall_hold--;
        out_stall <= stall_level;
    end

    always @(posedge clk)
    begin : check_parity
        parity_exp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (parity_due.size() == 0)
            begin
                report_mismatch("unexpected parity transfer", parity_byte, 8'h00);
            end
            else
            begin
                want = parity_due.pop_front();
                if (parity_byte !== want.value)
                begin
                    report_mismatch("parity_byte", parity_byte, want.value);
                end
                if (last_parity !== want.closing)
                begin
                    report_mismatch("last_parity", {7'b0, last_parity}, {7'b0, want.closing});
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        load_generator(rspe_pkg::PARITY_RESET);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_count();
        test_count_limits();
        test_mid_message_write();
        test_random_traffic();
        drain();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
